// ===== sv/wfg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfg_pkg
// shared constants, op codes and controller/datapath interface structs
// ----------------------------------------------------------------------------
package wfg_pkg;

  localparam int MAX_TXNS = 16;
  localparam int SLOT_W   = $clog2(MAX_TXNS);
  localparam int DEPTH_W  = $clog2(MAX_TXNS + 1);
  localparam int FIELD_W  = 4;

  typedef enum logic [1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_DEL_EDGE = 2'd1,
    OP_DEL_TXN  = 2'd2,
    OP_DETECT   = 2'd3
  } op_t;

  typedef struct packed {
    logic accept;
    logic root_try;
    logic step;
    logic scan;
    logic finish;
    logic load_out;
  } wfg_cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_seen;
    logic empty;
    logic hit;
    logic scan_done;
    logic out_free;
  } wfg_sts_t;

endpackage

// ===== sv/wfg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfg_ctrl
// sequencer for edits, the depth-first search and the victim scan
// ----------------------------------------------------------------------------
module wfg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  wfg_pkg::op_t      op,
  input  wfg_pkg::wfg_sts_t sts,
  output wfg_pkg::wfg_cmd_t cmd
);
  import wfg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_STEP,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = (op == OP_DETECT) ? S_ROOT : S_DONE;
        end
      end
      S_ROOT: begin
        if (sts.root_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.root_try = 1'b1;
          if (!sts.root_seen) state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.empty) begin
          state_nxt = S_ROOT;
        end else begin
          cmd.step = 1'b1;
          if (sts.hit) state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/wfg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfg_dp
// adjacency matrix, search stacks, victim scan and result register
// ----------------------------------------------------------------------------
module wfg_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wfg_pkg::op_t                   op,
  input  logic [wfg_pkg::FIELD_W-1:0]    waiter,
  input  logic [wfg_pkg::FIELD_W-1:0]    holder,
  input  wfg_pkg::wfg_cmd_t              cmd,
  output wfg_pkg::wfg_sts_t              sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           deadlock,
  output logic [wfg_pkg::FIELD_W-1:0]    victim
);
  import wfg_pkg::*;

  logic [MAX_TXNS-1:0] edges_r   [MAX_TXNS];
  logic [SLOT_W-1:0]   path_r    [MAX_TXNS];
  logic [DEPTH_W-1:0]  cursor_r  [MAX_TXNS];
  logic [MAX_TXNS-1:0] visited_r;
  logic [MAX_TXNS-1:0] onstack_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic [DEPTH_W-1:0]  root_r;
  logic [DEPTH_W-1:0]  k_r;
  logic [SLOT_W-1:0]   target_r;
  logic [SLOT_W-1:0]   best_r;
  logic                seen_r;
  logic                scan_r;
  logic                found_r;
  logic                out_valid_r;
  logic                out_dl_r;
  logic [FIELD_W-1:0]  out_victim_r;

  logic                w_ok, h_ok;
  logic [SLOT_W-1:0]   w_slot, h_slot;
  logic [SLOT_W-1:0]   top_idx, rd_idx, root_slot;
  logic [SLOT_W-1:0]   rd_node;
  logic [DEPTH_W-1:0]  cur;
  logic [MAX_TXNS-1:0] row, cand;
  logic                nb_any;
  logic [SLOT_W-1:0]   nb;
  logic                k_match;

  assign w_ok      = {1'b0, waiter} < (FIELD_W + 1)'(MAX_TXNS);
  assign h_ok      = {1'b0, holder} < (FIELD_W + 1)'(MAX_TXNS);
  assign w_slot    = SLOT_W'(waiter);
  assign h_slot    = SLOT_W'(holder);
  assign top_idx   = SLOT_W'(depth_r - DEPTH_W'(1));
  assign rd_idx    = scan_r ? k_r[SLOT_W-1:0] : top_idx;
  assign rd_node   = path_r[rd_idx];
  assign cur       = cursor_r[top_idx];
  assign row       = edges_r[rd_node];
  assign root_slot = root_r[SLOT_W-1:0];

  // lowest neighbor at or above the cursor
  always_comb begin
    for (int i = 0; i < MAX_TXNS; i++) begin
      cand[i] = row[i] && (DEPTH_W'(i) >= cur);
    end
    nb_any = |cand;
    nb     = '0;
    for (int i = MAX_TXNS - 1; i >= 0; i--) begin
      if (cand[i]) nb = SLOT_W'(i);
    end
  end

  assign k_match = seen_r || (rd_node == target_r);

  always_comb begin
    sts.root_done = (root_r == DEPTH_W'(MAX_TXNS));
    sts.root_seen = visited_r[root_slot];
    sts.empty     = (depth_r == '0);
    sts.hit       = nb_any && visited_r[nb] && onstack_r[nb];
    sts.scan_done = (k_r == depth_r);
    sts.out_free  = !out_valid_r || out_tready;
  end

  // adjacency matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TXNS; i++) edges_r[i] <= '0;
    end else if (cmd.accept) begin
      case (op)
        OP_ADD_EDGE: if (w_ok && h_ok) edges_r[w_slot][h_slot] <= 1'b1;
        OP_DEL_EDGE: if (w_ok && h_ok) edges_r[w_slot][h_slot] <= 1'b0;
        OP_DEL_TXN: begin
          if (w_ok) begin
            for (int i = 0; i < MAX_TXNS; i++) begin
              if (SLOT_W'(i) == w_slot) edges_r[i] <= '0;
              else edges_r[i][w_slot] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      onstack_r <= '0;
      depth_r   <= '0;
      root_r    <= '0;
      k_r       <= '0;
      seen_r    <= 1'b0;
      scan_r    <= 1'b0;
      found_r   <= 1'b0;
      best_r    <= '0;
      target_r  <= '0;
    end else begin
      if (cmd.accept) begin
        visited_r <= '0;
        onstack_r <= '0;
        depth_r   <= '0;
        root_r    <= '0;
        found_r   <= 1'b0;
        best_r    <= '0;
      end
      if (cmd.root_try) begin
        root_r <= root_r + DEPTH_W'(1);
        if (!visited_r[root_slot]) begin
          visited_r[root_slot]           <= 1'b1;
          onstack_r[root_slot]           <= 1'b1;
          path_r[depth_r[SLOT_W-1:0]]    <= root_slot;
          cursor_r[depth_r[SLOT_W-1:0]]  <= '0;
          depth_r                        <= depth_r + DEPTH_W'(1);
        end
      end
      if (cmd.step) begin
        if (!nb_any) begin
          onstack_r[rd_node] <= 1'b0;
          depth_r            <= depth_r - DEPTH_W'(1);
        end else begin
          cursor_r[top_idx] <= DEPTH_W'(nb) + DEPTH_W'(1);
          if (!visited_r[nb]) begin
            visited_r[nb]                 <= 1'b1;
            onstack_r[nb]                 <= 1'b1;
            path_r[depth_r[SLOT_W-1:0]]   <= nb;
            cursor_r[depth_r[SLOT_W-1:0]] <= '0;
            depth_r                       <= depth_r + DEPTH_W'(1);
          end else if (onstack_r[nb]) begin
            target_r <= nb;
            k_r      <= '0;
            seen_r   <= 1'b0;
            scan_r   <= 1'b1;
            best_r   <= '0;
          end
        end
      end
      if (cmd.scan) begin
        k_r <= k_r + DEPTH_W'(1);
        if (k_match) begin
          seen_r <= 1'b1;
          if (!seen_r || rd_node > best_r) best_r <= rd_node;
        end
      end
      if (cmd.finish) begin
        found_r <= 1'b1;
        scan_r  <= 1'b0;
        if (!seen_r || target_r > best_r) best_r <= target_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_dl_r     <= found_r;
      out_victim_r <= found_r ? FIELD_W'(best_r) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign deadlock   = out_dl_r;
  assign victim     = out_victim_r;

endmodule

// ===== sv/wait_for_graph_deadlock_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector
// wait-for graph with edge edits and depth-first cycle detection
//
//   channel  dir  tdata fields (lsb first)                tuser
//   in_      in   op[1:0] waiter[5:2] holder[9:6]         -
//   out_     out  deadlock[0] victim[4:1]                 -
//
// edits: accept goes to the done state, which loads the result register
// detect: tries each root in turn, examines one edge per step, pops exhausted
//   nodes and returns to the root loop after each tree; ends when the roots
//   run out or after the victim scan, then loads the result register
// one item at a time; next item accepted while the result waits
// a result not yet taken holds the block in its load cycle
// synchronous active-low reset clears the graph and all control state
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op, waiter, holder
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // deadlock, victim
);
  import wfg_pkg::*;

  op_t                op;
  logic [FIELD_W-1:0] waiter, holder, victim;
  logic               deadlock;
  wfg_cmd_t           cmd;
  wfg_sts_t           sts;

  assign op     = op_t'(in_tdata[1:0]);
  assign waiter = in_tdata[5:2];
  assign holder = in_tdata[9:6];

  wfg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .op        (op),
    .sts       (sts),
    .cmd       (cmd)
  );

  wfg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .waiter     (waiter),
    .holder     (holder),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .deadlock   (deadlock),
    .victim     (victim)
  );

  assign out_tdata = {3'b000, victim, deadlock};

endmodule

// ===== tb/sv/wait_for_graph_deadlock_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detector_test
// self-checking bench for the wait-for graph deadlock detector
//
// a scoreboard keeps its own copy of the adjacency matrix and runs the same
// ascending-order depth-first search on every detect, queuing one expected
// result per accepted item. a short directed sequence covers empty graphs,
// self edges, repeat adds, absent removes and transaction removal; random
// traffic then builds rings of random slots inside a moving window, mixed
// with edits, flushes and detects. both channels idle in random bursts, the
// receiver holds off once for a long stretch, and the tail runs at full rate.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector_test;
  import wfg_pkg::*;

  typedef struct packed {
    logic                deadlock;
    logic [SLOT_W-1:0]   victim;
  } verdict_t;

  class deadlock_scoreboard;
    logic [MAX_TXNS-1:0] wait_rows [MAX_TXNS];
    verdict_t            verdict_q [$];
    int                  mismatches;

    function new();
      foreach (wait_rows[i]) wait_rows[i] = '0;
      mismatches = 0;
    endfunction

    function bit search_cycle(output logic [SLOT_W-1:0] victim);
      logic [MAX_TXNS-1:0] visited;
      logic [MAX_TXNS-1:0] on_path;
      int path [MAX_TXNS];
      int cursor [MAX_TXNS];
      int depth;
      int node;
      int j;
      int k;
      int best;
      visited = '0;
      on_path = '0;
      depth = 0;
      victim = '0;
      for (int root = 0; root < MAX_TXNS; root++) begin
        if (visited[root]) continue;
        visited[root] = 1'b1;
        on_path[root] = 1'b1;
        path[0] = root;
        cursor[0] = 0;
        depth = 1;
        while (depth > 0) begin
          node = path[depth-1];
          j = cursor[depth-1];
          while (j < MAX_TXNS && !wait_rows[node][j]) j++;
          if (j >= MAX_TXNS) begin
            on_path[node] = 1'b0;
            depth--;
          end else begin
            cursor[depth-1] = j + 1;
            if (!visited[j]) begin
              visited[j] = 1'b1;
              on_path[j] = 1'b1;
              path[depth] = j;
              cursor[depth] = 0;
              depth++;
            end else if (on_path[j]) begin
              // cycle runs from the path entry equal to j up to the top
              k = 0;
              while (k < depth && path[k] != j) k++;
              best = j;
              for (; k < depth; k++) if (path[k] > best) best = path[k];
              victim = best[SLOT_W-1:0];
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_item(op_t op, logic [SLOT_W-1:0] waiter, logic [SLOT_W-1:0] holder);
      verdict_t v;
      v = '0;
      case (op)
        OP_ADD_EDGE: begin
          if (int'(waiter) < MAX_TXNS && int'(holder) < MAX_TXNS)
            wait_rows[waiter][holder] = 1'b1;
        end
        OP_DEL_EDGE: begin
          if (int'(waiter) < MAX_TXNS && int'(holder) < MAX_TXNS)
            wait_rows[waiter][holder] = 1'b0;
        end
        OP_DEL_TXN: begin
          if (int'(waiter) < MAX_TXNS) begin
            wait_rows[waiter] = '0;
            foreach (wait_rows[i]) wait_rows[i][waiter] = 1'b0;
          end
        end
        default: begin
          v.deadlock = search_cycle(v.victim);
        end
      endcase
      verdict_q.insert(verdict_q.size(), v);
    endfunction

    function void check_result(logic deadlock, logic [SLOT_W-1:0] victim);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result deadlock=%0b victim=%0d", $realtime, deadlock,
                   victim);
        return;
      end
      v = verdict_q.pop_front();
      if (deadlock !== v.deadlock || victim !== v.victim) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch, exp deadlock=%0b victim=%0d, got deadlock=%0b victim=%0d",
                   $realtime, v.deadlock, v.victim, deadlock, victim);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function bit clean();
      return mismatches == 0 && verdict_q.size() == 0;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // op, waiter, holder
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // deadlock, victim

  deadlock_scoreboard sb = new();

  int n_sent;
  int win_base;
  int win_span;
  bit quiet;
  bit hold_req;

  wait_for_graph_deadlock_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("wait_for_graph_deadlock_detector_test: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[0], out_tdata[SLOT_W:1]);
  end

  // receiver: random ready runs and stalls, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet || $urandom_range(2) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(4) != 0)
      return SLOT_W'((win_base + $urandom_range(win_span - 1)) % MAX_TXNS);
    return SLOT_W'($urandom_range(MAX_TXNS - 1));
  endfunction

  task automatic send_item(op_t op, logic [SLOT_W-1:0] waiter, logic [SLOT_W-1:0] holder);
    if (!quiet && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, holder, waiter, op};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, waiter, holder);
    n_sent++;
  endtask

  // ring of random slots, then detect, sometimes drop one member
  task automatic issue_ring();
    logic [SLOT_W-1:0] ring [5];
    int k;
    k = $urandom_range(1, 5);
    for (int i = 0; i < k; i++) ring[i] = pick_slot();
    for (int i = 0; i < k; i++) send_item(OP_ADD_EDGE, ring[i], ring[(i + 1) % k]);
    send_item(OP_DETECT, SLOT_W'($urandom_range(15)), SLOT_W'($urandom_range(15)));
    if ($urandom_range(1) == 0)
      send_item(OP_DEL_TXN, ring[$urandom_range(k - 1)], SLOT_W'($urandom_range(15)));
  endtask

  initial begin
    int r;
    int next_window;
    int guard;
    bit hold_done;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    n_sent     = 0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    win_base   = 0;
    win_span   = 4;
    next_window = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_item(OP_DETECT,   4'd0,  4'd0);
    send_item(OP_ADD_EDGE, 4'd5,  4'd5);
    send_item(OP_DETECT,   4'd15, 4'd15);
    send_item(OP_DEL_EDGE, 4'd5,  4'd5);
    send_item(OP_DETECT,   4'd0,  4'd0);
    send_item(OP_ADD_EDGE, 4'd0,  4'd15);
    send_item(OP_ADD_EDGE, 4'd15, 4'd0);
    send_item(OP_ADD_EDGE, 4'd0,  4'd15);
    send_item(OP_DETECT,   4'd0,  4'd0);
    send_item(OP_DEL_EDGE, 4'd3,  4'd7);
    send_item(OP_DEL_TXN,  4'd15, 4'd0);
    send_item(OP_DETECT,   4'd0,  4'd0);
    send_item(OP_ADD_EDGE, 4'd1,  4'd2);
    send_item(OP_ADD_EDGE, 4'd2,  4'd3);
    send_item(OP_ADD_EDGE, 4'd3,  4'd1);
    send_item(OP_ADD_EDGE, 4'd0,  4'd1);
    send_item(OP_DETECT,   4'd0,  4'd0);
    send_item(OP_DEL_EDGE, 4'd3,  4'd1);
    send_item(OP_ADD_EDGE, 4'd3,  4'd0);
    send_item(OP_DETECT,   4'd0,  4'd0);
    send_item(OP_DEL_TXN,  4'd0,  4'd15);
    send_item(OP_DETECT,   4'd0,  4'd0);
    send_item(OP_ADD_EDGE, 4'd10, 4'd9);
    send_item(OP_ADD_EDGE, 4'd9,  4'd10);
    send_item(OP_DETECT,   4'd0,  4'd0);

    // random
    while (n_sent < 750) begin
      quiet = (n_sent >= 650);
      if (!hold_done && n_sent >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (n_sent >= next_window) begin
        win_span    = ($urandom_range(4) == 0) ? MAX_TXNS : $urandom_range(2, 6);
        win_base    = $urandom_range(MAX_TXNS - 1);
        next_window = n_sent + 60;
        if ($urandom_range(2) == 0)
          for (int s = 0; s < MAX_TXNS; s++)
            send_item(OP_DEL_TXN, SLOT_W'(s), SLOT_W'($urandom_range(15)));
      end
      r = $urandom_range(99);
      if (r < 20)
        issue_ring();
      else if (r < 50)
        send_item(OP_ADD_EDGE, pick_slot(), pick_slot());
      else if (r < 62)
        send_item(OP_DEL_EDGE, pick_slot(), pick_slot());
      else if (r < 70)
        send_item(OP_DEL_TXN, pick_slot(), SLOT_W'($urandom_range(15)));
      else
        send_item(OP_DETECT, SLOT_W'($urandom_range(15)), SLOT_W'($urandom_range(15)));
    end

    in_tvalid <= 1'b0;
    guard = 0;
    while (sb.pending() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
    if (sb.clean())
      $display("wait_for_graph_deadlock_detector_test: clean");
    else
      $display("wait_for_graph_deadlock_detector_test: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wfg_pkg.sv
sv/wfg_ctrl.sv
sv/wfg_dp.sv
sv/wait_for_graph_deadlock_detector.sv
tb/sv/wait_for_graph_deadlock_detector_test.sv
